>>> src/crv_pkg.sv
`timescale 1ns / 1ps
package crv_pkg;

    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC_RESET    = 32'h4346_4731;
    localparam logic [31:0] VERSION_RESET  = 32'd1;
    localparam logic [7:0]  ERASED_BYTE    = 8'hFF;
    localparam int          HDR_LEN        = 16;
    localparam int          TRAILER_LEN    = 16;

    localparam int          PADDR_W        = 3;
    localparam logic        REG_MAGIC      = 1'b0;
    localparam logic        REG_VERSION    = 1'b1;

    localparam logic [1:0]  ST_OK          = 2'd0;
    localparam logic [1:0]  ST_ERASED      = 2'd1;
    localparam logic [1:0]  ST_INVALID     = 2'd2;

    typedef struct packed {
        logic ok;
        logic erased;
        logic bank;
    } t_report;

    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] data;
    } t_name_wr;

    typedef struct packed {
        logic done;
        logic bank;
    } t_bank_done;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> src/crv_if.sv
`timescale 1ns / 1ps
interface crv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface crv_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] name_byte;
    logic       last;

    modport source (output valid, output status, output name_byte, output last, input ready);
    modport sink (input valid, input status, input name_byte, input last, output ready);
endinterface

>>> src/crv_queue.sv
`timescale 1ns / 1ps
module crv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  crv_pkg::t_report i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output crv_pkg::t_report o_pop_data
);
    import crv_pkg::*;

    t_report    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full     = (r_count == 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> src/crv_front.sv
`timescale 1ns / 1ps
module crv_front #(
    parameter int NAME_LEN = 31
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    crv_in_if.sink                              in_ch,
    input  logic [31:0]                         i_expected_magic,
    input  logic [31:0]                         i_expected_version,
    output logic                                o_push,
    output crv_pkg::t_report                    o_report,
    input  logic                                i_q_full,
    output crv_pkg::t_name_wr                   o_name_wr,
    output logic [$clog2(NAME_LEN + 1)-1:0]     o_name_idx,
    input  crv_pkg::t_bank_done                 i_bank_done
);
    import crv_pkg::*;

    localparam int NAME_FIELD = NAME_LEN + 1;
    localparam int NIDX_W     = $clog2(NAME_FIELD);
    localparam int CRC_OFF    = HDR_LEN + ((NAME_FIELD + 3) / 4) * 4;
    localparam int REC_LEN    = ((CRC_OFF + TRAILER_LEN + 15) / 16) * 16;
    localparam int POS_W      = $clog2(REC_LEN);

    localparam logic [POS_W-1:0] P_MAGIC    = POS_W'(3);
    localparam logic [POS_W-1:0] P_VERSION  = POS_W'(7);
    localparam logic [POS_W-1:0] P_SIZE     = POS_W'(11);
    localparam logic [POS_W-1:0] P_NAME_LO  = POS_W'(HDR_LEN);
    localparam logic [POS_W-1:0] P_NAME_HI  = POS_W'(HDR_LEN + NAME_FIELD - 1);
    localparam logic [POS_W-1:0] P_CRC_OFF  = POS_W'(CRC_OFF);
    localparam logic [POS_W-1:0] P_CRC_LAST = POS_W'(CRC_OFF - 1);
    localparam logic [POS_W-1:0] P_CRC_CHK  = POS_W'(CRC_OFF + 3);
    localparam logic [POS_W-1:0] P_END      = POS_W'(REC_LEN - 1);
    localparam logic [31:0]      SIZE_WORD  = 32'(NAME_FIELD);

    logic [POS_W-1:0] r_pos;
    logic [31:0]      r_crc;
    logic [31:0]      r_shift;
    logic             r_good;
    logic             r_erased;
    logic [31:0]      r_hold;
    logic             r_bank;
    logic [1:0]       r_busy;

    logic [POS_W-1:0] w_pos;
    logic [31:0]      w_crc;
    logic [31:0]      w_shift;
    logic             w_good;
    logic             w_erased;
    logic [31:0]      w_hold;
    logic [31:0]      n_crc;
    logic [31:0]      n_shift;
    logic             n_good;
    logic             n_erased;
    logic [31:0]      n_hold;
    logic [1:0]       n_busy;
    logic             w_accept;
    logic             w_in_name;
    logic             w_end;
    logic [POS_W-1:0] w_name_off;

    assign in_ch.ready = !((r_pos == P_END) && i_q_full)
                      && !((r_pos >= P_NAME_LO) && (r_pos <= P_NAME_HI) && r_busy[r_bank]);
    assign w_accept    = in_ch.valid && in_ch.ready;

    always_comb begin
        if (in_ch.first_byte) begin
            w_pos    = '0;
            w_crc    = CRC_INIT;
            w_shift  = '0;
            w_good   = 1'b1;
            w_erased = 1'b1;
            w_hold   = '0;
        end else begin
            w_pos    = r_pos;
            w_crc    = r_crc;
            w_shift  = r_shift;
            w_good   = r_good;
            w_erased = r_erased;
            w_hold   = r_hold;
        end
        n_crc    = (w_pos < P_CRC_OFF) ? crc_byte(w_crc, in_ch.data_byte) : w_crc;
        n_hold   = (w_pos == P_CRC_LAST) ? ~n_crc : w_hold;
        n_erased = w_erased && (in_ch.data_byte == ERASED_BYTE);
        n_shift  = {in_ch.data_byte, w_shift[31:8]};
        n_good   = w_good;
        if ((w_pos == P_MAGIC) && (n_shift != i_expected_magic)) begin
            n_good = 1'b0;
        end
        if ((w_pos == P_VERSION) && (n_shift != i_expected_version)) begin
            n_good = 1'b0;
        end
        if ((w_pos == P_SIZE) && (n_shift != SIZE_WORD)) begin
            n_good = 1'b0;
        end
        if ((w_pos == P_CRC_CHK) && (n_shift != w_hold)) begin
            n_good = 1'b0;
        end
    end

    assign w_in_name  = (w_pos >= P_NAME_LO) && (w_pos <= P_NAME_HI);
    assign w_name_off = w_pos - P_NAME_LO;
    assign w_end      = (w_pos == P_END);

    always_comb begin
        n_busy = r_busy;
        if (i_bank_done.done) begin
            n_busy[i_bank_done.bank] = 1'b0;
        end
        if (w_accept && w_end && n_good) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    assign o_name_wr.en   = w_accept && w_in_name;
    assign o_name_wr.bank = r_bank;
    assign o_name_wr.data = in_ch.data_byte;
    assign o_name_idx     = w_name_off[NIDX_W-1:0];

    assign o_push          = w_accept && w_end;
    assign o_report.ok     = n_good;
    assign o_report.erased = n_erased;
    assign o_report.bank   = r_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= CRC_INIT;
            r_shift  <= '0;
            r_good   <= 1'b1;
            r_erased <= 1'b1;
            r_hold   <= '0;
            r_bank   <= 1'b0;
            r_busy   <= 2'b00;
        end else begin
            r_busy <= n_busy;
            if (w_accept) begin
                if (w_end) begin
                    r_pos    <= '0;
                    r_crc    <= CRC_INIT;
                    r_shift  <= '0;
                    r_good   <= 1'b1;
                    r_erased <= 1'b1;
                    r_hold   <= '0;
                    if (n_good) begin
                        r_bank <= !r_bank;
                    end
                end else begin
                    r_pos    <= w_pos + POS_W'(1);
                    r_crc    <= n_crc;
                    r_shift  <= n_shift;
                    r_good   <= n_good;
                    r_erased <= n_erased;
                    r_hold   <= n_hold;
                end
            end
        end
    end

endmodule

>>> src/crv_back.sv
`timescale 1ns / 1ps
module crv_back #(
    parameter int NAME_LEN = 31
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  crv_pkg::t_report                    i_report,
    output logic                                o_pop,
    input  crv_pkg::t_name_wr                   i_name_wr,
    input  logic [$clog2(NAME_LEN + 1)-1:0]     i_name_idx,
    output crv_pkg::t_bank_done                 o_bank_done,
    crv_out_if.source                           out_ch
);
    import crv_pkg::*;

    localparam int NAME_FIELD = NAME_LEN + 1;
    localparam int NIDX_W     = $clog2(NAME_FIELD);
    localparam int MEM_DEPTH  = 1 << (NIDX_W + 1);
    localparam logic [NIDX_W-1:0] IDX_LAST = NIDX_W'(NAME_FIELD - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_rd_data;
    logic [NIDX_W-1:0] r_idx;
    logic              r_bank;
    logic              r_name_mode;
    logic [1:0]        r_status;
    logic              w_last;
    logic              w_take;

    always_ff @(posedge i_clk) begin
        if (i_name_wr.en) begin
            r_mem[{i_name_wr.bank, i_name_idx}] <= i_name_wr.data;
        end
        r_rd_data <= r_mem[{r_bank, r_idx}];
    end

    assign w_last = !r_name_mode || (r_idx == IDX_LAST);
    assign w_take = out_ch.valid && out_ch.ready;
    assign o_pop  = (r_state == S_IDLE) && i_q_valid;

    assign out_ch.valid     = (r_state == S_EMIT);
    assign out_ch.status    = r_status;
    assign out_ch.last      = w_last;
    assign out_ch.name_byte = (r_name_mode && !w_last) ? r_rd_data : 8'd0;

    assign o_bank_done.done = w_take && r_name_mode && w_last;
    assign o_bank_done.bank = r_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_bank      <= 1'b0;
            r_name_mode <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_idx       <= '0;
                        r_bank      <= i_report.bank;
                        r_name_mode <= i_report.ok;
                        if (i_report.ok) begin
                            r_status <= ST_OK;
                            r_state  <= S_FETCH;
                        end else begin
                            r_status <= i_report.erased ? ST_ERASED : ST_INVALID;
                            r_state  <= S_EMIT;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_take) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + NIDX_W'(1);
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/config_record_validator.sv
`timescale 1ns / 1ps
// Checks a stored configuration record streamed in one byte per request, in address order,
// and reports ok, not found (all bytes erased) or invalid data when the record's last byte
// arrives; on ok it returns the NAME_LEN+1 name bytes, the final one zero, with last on the
// final result. A set first_byte restarts checking at byte 0. The front end takes one byte
// per cycle, running the CRC-32 a byte per cycle. A short report queue parts it from the
// output side, which takes a report from the queue while idle, then for each name result
// reads the name memory and then drives the output stage, or drives the output stage
// directly for a failure report. The name memory holds two records, so the front end
// only waits on the name bytes of a record when both banks still hold names not yet
// sent, and on the last byte of a record when the report queue is full.
module config_record_validator #(
    parameter int NAME_LEN = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    crv_in_if.sink                       i_in,
    crv_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crv_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import crv_pkg::*;

    localparam int NIDX_W = $clog2(NAME_LEN + 1);

    logic [31:0]       r_magic;
    logic [31:0]       r_version;
    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_valid;
    t_report           w_push_data;
    t_report           w_pop_data;
    t_name_wr          w_name_wr;
    logic [NIDX_W-1:0] w_name_idx;
    t_bank_done        w_bank_done;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERSION) ? r_version : r_magic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RESET;
            r_version <= VERSION_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_MAGIC) begin
                r_magic <= pwdata;
            end else begin
                r_version <= pwdata;
            end
        end
    end

    crv_front #(
        .NAME_LEN (NAME_LEN)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .in_ch              (i_in),
        .i_expected_magic   (r_magic),
        .i_expected_version (r_version),
        .o_push             (w_push),
        .o_report           (w_push_data),
        .i_q_full           (w_q_full),
        .o_name_wr          (w_name_wr),
        .o_name_idx         (w_name_idx),
        .i_bank_done        (w_bank_done)
    );

    crv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_pop_data  (w_pop_data)
    );

    crv_back #(
        .NAME_LEN (NAME_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_report    (w_pop_data),
        .o_pop       (w_pop),
        .i_name_wr   (w_name_wr),
        .i_name_idx  (w_name_idx),
        .o_bank_done (w_bank_done),
        .out_ch      (o_out)
    );

endmodule
